// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the splitter modules.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset only.
`define AUS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every edge, reset included.
`define AUS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/aus_pkg.sv =====
// ----------------------------------------------------------------------------
// aus_pkg: shared types and constants for the Annex B access unit splitter
// Offset width, NAL kind codes, record layout and the result queue size.
// ----------------------------------------------------------------------------
package aus_pkg;

  localparam int OFFSET_BITS = 32;
  typedef logic [OFFSET_BITS-1:0] off_t;

  localparam int PERIOD_W = 10;
  localparam int COUNT_W  = 32;
  localparam int PROD_W   = PERIOD_W + COUNT_W;
  localparam int TIME_W   = 48;

  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = PERIOD_W'(40);

  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_NONE = 5'd0;

  localparam logic [7:0] KIND_MASK     = 8'h1F;
  localparam logic [7:0] SLICE_TOP_BIT = 8'h80;

  localparam logic REC_UNIT  = 1'b0;
  localparam logic REC_PARAM = 1'b1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic               kind;
    logic [31:0]        offset;
    logic [31:0]        length;
    logic [COUNT_W-1:0] count;
    logic               idr;
    logic               last;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  function automatic logic is_slice(input logic [4:0] k);
    return (k >= 5'd1) && (k <= 5'd5);
  endfunction

  function automatic logic is_param_set(input logic [4:0] k);
    return (k == NAL_SPS) || (k == NAL_PPS);
  endfunction

  function automatic rec_t mk_unit(input off_t pend, input off_t end_off,
                                   input logic [COUNT_W-1:0] cnt,
                                   input logic [4:0] k);
    rec_t r;
    r.kind   = REC_UNIT;
    r.offset = 32'(pend);
    r.length = 32'(off_t'(end_off - pend));
    r.count  = cnt;
    r.idr    = (k == NAL_IDR);
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic rec_t mk_param(input off_t nal_start, input logic long_code,
                                    input off_t pend, input off_t end_off);
    rec_t r;
    r.kind   = REC_PARAM;
    r.offset = 32'(off_t'(nal_start + (long_code ? off_t'(4) : off_t'(3))));
    r.length = 32'(off_t'(end_off - pend));
    r.count  = '0;
    r.idr    = 1'b0;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/aus_step.sv =====
// ----------------------------------------------------------------------------
// aus_step: input register and per-byte parser
// Holds one request, runs start code detection and unit closing in one pass,
// and hands up to two records to the result queue.
// ----------------------------------------------------------------------------
module aus_step
  import aus_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       room_ok,
  output push_t      push
);

  logic       in_q_valid;
  logic [7:0] byte_q;
  logic       last_q;
  logic       go;

  logic [23:0]        hist, hist_next;
  off_t               offset, offset_next;
  logic               found, found_next;
  off_t               pend, pend_next;
  off_t               nal_start, nal_start_next;
  logic               is_long, is_long_next;
  logic [4:0]         nal_kind, nal_kind_next;
  logic [1:0]         bac, bac_next;
  logic               dec_pend, dec_pend_next;
  logic [4:0]         close_kind, close_kind_next;
  off_t               close_end, close_end_next;
  logic [COUNT_W-1:0] frame_count, frame_count_next;
  logic               collect, collect_next;
  logic               ps_seen, ps_seen_next;

  logic       code;
  logic       eligible;
  off_t       q;
  off_t       end_off;
  logic [1:0] cnt;
  rec_t       r0, r1, rec;

  assign go       = in_q_valid && room_ok;
  assign in_stall = in_q_valid && !room_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

  always_comb begin
    hist_next        = hist;
    offset_next      = offset;
    found_next       = found;
    pend_next        = pend;
    nal_start_next   = nal_start;
    is_long_next     = is_long;
    nal_kind_next    = nal_kind;
    bac_next         = bac;
    dec_pend_next    = dec_pend;
    close_kind_next  = close_kind;
    close_end_next   = close_end;
    frame_count_next = frame_count;
    collect_next     = collect;
    ps_seen_next     = ps_seen;
    cnt = 2'd0;
    r0  = '0;
    r1  = '0;
    rec = '0;
    q   = off_t'(offset - off_t'(3));
    end_off = off_t'(offset + off_t'(1));

    eligible = found ? (bac == 2'd3) : (offset >= off_t'(3));
    code = eligible && (hist[23:16] == 8'd0) && (hist[15:8] == 8'd0) &&
           ((hist[7:0] == 8'd1) || ((hist[7:0] == 8'd0) && (byte_q == 8'd1)));

    hist_next = {hist[15:0], byte_q};

    if (code) begin
      if (!found) begin
        found_next = 1'b1;
        pend_next  = q;
      end else if (is_param_set(nal_kind) && collect) begin
        rec = mk_param(nal_start, is_long, pend_next, q);
        if (cnt == 2'd0) r0 = rec; else r1 = rec;
        cnt = cnt + 2'd1;
        ps_seen_next = 1'b1;
      end else if (is_slice(nal_kind)) begin
        dec_pend_next   = 1'b1;
        close_kind_next = nal_kind;
        close_end_next  = q;
      end
      nal_start_next = q;
      is_long_next   = (hist[7:0] == 8'd0);
      nal_kind_next  = is_long_next ? NAL_NONE : 5'(byte_q & KIND_MASK);
      bac_next       = 2'd0;
      if (!is_long_next && dec_pend_next && !is_slice(nal_kind_next)) begin
        // close the pending unit on a non-slice header
        dec_pend_next = 1'b0;
        rec = mk_unit(pend_next, close_end_next, frame_count_next, close_kind_next);
        if (cnt == 2'd0) r0 = rec; else r1 = rec;
        cnt = cnt + 2'd1;
        if (ps_seen_next) collect_next = 1'b0;
        frame_count_next = frame_count_next + 1'b1;
        pend_next = close_end_next;
      end
    end else if (found) begin
      if (is_long && (bac == 2'd0)) begin
        nal_kind_next = 5'(byte_q & KIND_MASK);
        if (dec_pend_next && !is_slice(nal_kind_next)) begin
          dec_pend_next = 1'b0;
          rec = mk_unit(pend_next, close_end_next, frame_count_next, close_kind_next);
          if (cnt == 2'd0) r0 = rec; else r1 = rec;
          cnt = cnt + 2'd1;
          if (ps_seen_next) collect_next = 1'b0;
          frame_count_next = frame_count_next + 1'b1;
          pend_next = close_end_next;
        end
      end else if (dec_pend_next && ((!is_long && (bac == 2'd0)) ||
                                     (is_long && (bac == 2'd1)))) begin
        // first slice byte: top bit set starts a new picture
        if ((byte_q & SLICE_TOP_BIT) != 8'd0) begin
          dec_pend_next = 1'b0;
          rec = mk_unit(pend_next, close_end_next, frame_count_next, close_kind_next);
          if (cnt == 2'd0) r0 = rec; else r1 = rec;
          cnt = cnt + 2'd1;
          if (ps_seen_next) collect_next = 1'b0;
          frame_count_next = frame_count_next + 1'b1;
          pend_next = close_end_next;
        end else begin
          dec_pend_next = 1'b0;
        end
      end
      bac_next = (bac < 2'd3) ? (bac + 2'd1) : 2'd3;
    end

    offset_next = end_off;

    if (last_q) begin
      // flush at stream end
      if (dec_pend_next) begin
        dec_pend_next = 1'b0;
        rec = mk_unit(pend_next, close_end_next, frame_count_next, close_kind_next);
        if (cnt == 2'd0) r0 = rec; else r1 = rec;
        cnt = cnt + 2'd1;
        if (ps_seen_next) collect_next = 1'b0;
        frame_count_next = frame_count_next + 1'b1;
        pend_next = close_end_next;
      end
      if (found_next && (!is_long_next || (bac_next >= 2'd1))) begin
        if (is_slice(nal_kind_next)) begin
          rec = mk_unit(pend_next, end_off, frame_count_next, nal_kind_next);
          if (cnt == 2'd0) r0 = rec; else r1 = rec;
          cnt = cnt + 2'd1;
        end else if (is_param_set(nal_kind_next) && collect_next) begin
          rec = mk_param(nal_start_next, is_long_next, pend_next, end_off);
          if (cnt == 2'd0) r0 = rec; else r1 = rec;
          cnt = cnt + 2'd1;
        end
      end
      hist_next        = '0;
      offset_next      = '0;
      found_next       = 1'b0;
      pend_next        = '0;
      nal_start_next   = '0;
      is_long_next     = 1'b0;
      nal_kind_next    = NAL_NONE;
      bac_next         = 2'd0;
      dec_pend_next    = 1'b0;
      close_kind_next  = NAL_NONE;
      close_end_next   = '0;
      frame_count_next = '0;
      collect_next     = 1'b1;
      ps_seen_next     = 1'b0;
    end

    if (cnt == 2'd1) r0.last = 1'b1;
    if (cnt == 2'd2) r1.last = 1'b1;

    push.n  = go ? cnt : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist        <= '0;
      offset      <= '0;
      found       <= 1'b0;
      pend        <= '0;
      nal_start   <= '0;
      is_long     <= 1'b0;
      nal_kind    <= NAL_NONE;
      bac         <= 2'd0;
      dec_pend    <= 1'b0;
      close_kind  <= NAL_NONE;
      close_end   <= '0;
      frame_count <= '0;
      collect     <= 1'b1;
      ps_seen     <= 1'b0;
    end else if (go) begin
      hist        <= hist_next;
      offset      <= offset_next;
      found       <= found_next;
      pend        <= pend_next;
      nal_start   <= nal_start_next;
      is_long     <= is_long_next;
      nal_kind    <= nal_kind_next;
      bac         <= bac_next;
      dec_pend    <= dec_pend_next;
      close_kind  <= close_kind_next;
      close_end   <= close_end_next;
      frame_count <= frame_count_next;
      collect     <= collect_next;
      ps_seen     <= ps_seen_next;
    end
  end

`include "assert_macros.svh"

  `AUS_ASSERT(a_flush_clears, (go && last_q) |=> (!found && collect && !dec_pend), "flush did not restore parse state")
  `AUS_ASSERT(a_pend_needs_code, !found |-> !dec_pend, "unit decision pending before any start code")

endmodule

// ===== hdl/aus_out_queue.sv =====
// ----------------------------------------------------------------------------
// aus_out_queue: result queue and output register
// Buffers up to two records per request and presents one per cycle while out_stall is
// low; the frame time product is formed on the way into the output register.
// ----------------------------------------------------------------------------
module aus_out_queue
  import aus_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  push_t               push,
  input  logic [PERIOD_W-1:0] frame_period,
  output logic                room_ok,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                record_kind,
  output logic [31:0]         unit_offset,
  output logic [31:0]         unit_length,
  output logic [TIME_W-1:0]   frame_time,
  output logic                is_idr,
  output logic                last_result
);

  rec_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   cnt;
  logic            pop;
  rec_t            head;
  logic [PROD_W-1:0] prod;

  assign room_ok = (cnt <= (Q_AW+1)'(Q_DEPTH - 2));
  assign pop     = (cnt != '0) && (!out_valid || !out_stall);
  assign head    = mem[rd_ptr];
  assign prod    = PROD_W'(frame_period) * PROD_W'(head.count);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[Q_AW'(wr_ptr + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= Q_AW'(wr_ptr + push.n);
      if (pop) rd_ptr <= Q_AW'(rd_ptr + 1'b1);
      cnt <= (Q_AW+1)'(cnt + push.n - (pop ? 1'b1 : 1'b0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= (cnt != '0);
    end
    if (pop) begin
      record_kind <= head.kind;
      unit_offset <= head.offset;
      unit_length <= head.length;
      frame_time  <= (head.kind == REC_PARAM) ? '0 : TIME_W'(prod);
      is_idr      <= head.idr;
      last_result <= head.last;
    end
  end

`include "assert_macros.svh"

  `AUS_ASSERT(a_no_overflow, (push.n != 2'd0) |-> (cnt <= (Q_AW+1)'(Q_DEPTH - 2)), "push into a queue without room")
  `AUS_ASSERT(a_cnt_bound, cnt <= (Q_AW+1)'(Q_DEPTH), "queue count beyond depth")

endmodule

// ===== hdl/annexb_access_unit_splitter.sv =====
// Path: a result goes from its accepted byte through the input register, the parse into the
//   result queue and the output register, and waits while the output is stalled.
// Throughput: one byte per cycle; results leave one per cycle while out_stall is low,
//   via a four-entry queue; input stalls while fewer than two queue slots are free.
// Reset: synchronous, active high; clears parse state and queue, frame_period to 40.
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter: H.264 Annex B access unit splitter
// Finds start codes in a byte stream and reports access units and parameter sets.
// ----------------------------------------------------------------------------
module annexb_access_unit_splitter
  import aus_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                record_kind,
  output logic [31:0]         unit_offset,
  output logic [31:0]         unit_length,
  output logic [TIME_W-1:0]   frame_time,
  output logic                is_idr,
  output logic                last_result
);

  logic [PERIOD_W-1:0] frame_period;
  logic                room_ok;
  push_t               push;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= FRAME_PERIOD_RESET;
    end else if (cfg_we) begin
      frame_period <= cfg_wdata;
    end
  end

  aus_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .room_ok   (room_ok),
    .push      (push)
  );

  aus_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .frame_period (frame_period),
    .room_ok      (room_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_kind  (record_kind),
    .unit_offset  (unit_offset),
    .unit_length  (unit_length),
    .frame_time   (frame_time),
    .is_idr       (is_idr),
    .last_result  (last_result)
  );

endmodule

// ===== tb/tb_annexb_access_unit_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_annexb_access_unit_splitter: self-checking bench for the Annex B splitter
// Feeds directed and random byte streams with random idling on both sides,
// predicts every access unit and parameter set record, and checks each one.
// ----------------------------------------------------------------------------
module tb_annexb_access_unit_splitter;
  import aus_pkg::*;

  localparam int LIMIT_NS     = 3_000_000;
  localparam int RANDOM_BYTES = 1200;
  localparam int PHASES       = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED  = 20;

  typedef struct {
    logic              kind;
    logic [31:0]       offset;
    logic [31:0]       length;
    logic [TIME_W-1:0] ftime;
    logic              idr;
    logic              last;
  } unit_record_t;

  // Tracks the splitter's parse state and holds the records it should emit.
  class au_scoreboard;
    logic [PERIOD_W-1:0] period;
    logic [31:0]         window;
    off_t                offs;
    bit                  found;
    off_t                pend;
    off_t                nal_start;
    bit                  long_code;
    logic [4:0]          nal_kind;
    logic [1:0]          tail_bytes;
    bit                  deciding;
    logic [4:0]          close_kind;
    off_t                close_end;
    logic [COUNT_W-1:0]  frames;
    bit                  collecting;
    bit                  ps_seen;
    unit_record_t        expected_records[$];
    int                  errors;
    int                  units_checked;
    int                  params_checked;

    function new();
      period = FRAME_PERIOD_RESET;
      errors = 0;
      units_checked = 0;
      params_checked = 0;
      restart();
    endfunction

    function void restart();
      window     = '0;
      offs       = '0;
      found      = 1'b0;
      pend       = '0;
      nal_start  = '0;
      long_code  = 1'b0;
      nal_kind   = NAL_NONE;
      tail_bytes = '0;
      deciding   = 1'b0;
      close_kind = NAL_NONE;
      close_end  = '0;
      frames     = '0;
      collecting = 1'b1;
      ps_seen    = 1'b0;
    endfunction

    function bit slice_kind(logic [4:0] k);
      return (k >= 5'd1) && (k <= 5'd5);
    endfunction

    function bit param_kind(logic [4:0] k);
      return (k == NAL_SPS) || (k == NAL_PPS);
    endfunction

    function void push_unit(off_t end_off, logic [4:0] k);
      unit_record_t r;
      r.kind   = REC_UNIT;
      r.offset = 32'(pend);
      r.length = 32'(off_t'(end_off - pend));
      r.ftime  = TIME_W'(period) * TIME_W'(frames);
      r.idr    = (k == NAL_IDR);
      r.last   = 1'b0;
      expected_records.insert(expected_records.size(), r);
      if (ps_seen) collecting = 1'b0;
      frames = frames + 1;
      pend = end_off;
    endfunction

    function void push_param(off_t end_off);
      unit_record_t r;
      r.kind   = REC_PARAM;
      r.offset = 32'(off_t'(nal_start + (long_code ? off_t'(4) : off_t'(3))));
      r.length = 32'(off_t'(end_off - pend));
      r.ftime  = '0;
      r.idr    = 1'b0;
      r.last   = 1'b0;
      expected_records.insert(expected_records.size(), r);
      ps_seen = 1'b1;
    endfunction

    function void close_unit();
      deciding = 1'b0;
      push_unit(close_end, close_kind);
    endfunction

    // Advance the parse state by one accepted byte request.
    function void note_byte(logic [7:0] b, logic l);
      off_t       t;
      logic [1:0] prior;
      int         n0;
      logic [7:0] b0, b1, b2;
      bit         eligible, code;
      off_t       q;
      t     = offs;
      prior = tail_bytes;
      n0    = expected_records.size();
      window = {window[23:0], b};
      b0 = window[31:24];
      b1 = window[23:16];
      b2 = window[15:8];
      eligible = found ? (prior == 2'd3) : (t >= off_t'(3));
      code = eligible && b0 == 8'h00 && b1 == 8'h00 &&
             (b2 == 8'h01 || (b2 == 8'h00 && b == 8'h01));
      if (code) begin
        q = t - off_t'(3);
        if (!found) begin
          found = 1'b1;
          pend = q;
        end else if (param_kind(nal_kind) && collecting) begin
          push_param(q);
        end else if (slice_kind(nal_kind)) begin
          deciding = 1'b1;
          close_kind = nal_kind;
          close_end = q;
        end
        nal_start = q;
        long_code = (b2 == 8'h00);
        nal_kind = long_code ? NAL_NONE : (b[4:0] & KIND_MASK[4:0]);
        tail_bytes = '0;
        if (!long_code && deciding && !slice_kind(nal_kind)) close_unit();
      end else if (found) begin
        if (long_code && prior == 2'd0) begin
          // header byte of a long code arrives one byte after its 01
          nal_kind = b[4:0];
          if (deciding && !slice_kind(nal_kind)) close_unit();
        end else if (deciding && ((!long_code && prior == 2'd0) ||
                                  (long_code && prior == 2'd1))) begin
          if ((b & SLICE_TOP_BIT) != 8'h00) close_unit();
          else deciding = 1'b0;
        end
        tail_bytes = (prior < 2'd3) ? prior + 2'd1 : 2'd3;
      end
      offs = t + off_t'(1);
      if (l) begin
        if (deciding) close_unit();
        if (found && (!long_code || tail_bytes >= 2'd1)) begin
          if (slice_kind(nal_kind)) push_unit(offs, nal_kind);
          else if (param_kind(nal_kind) && collecting) push_param(offs);
        end
        restart();
      end
      if (expected_records.size() > n0)
        expected_records[expected_records.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task check_record(logic kind, logic [31:0] offset, logic [31:0] length,
                      logic [TIME_W-1:0] ftime, logic idr, logic last);
      unit_record_t w;
      if (expected_records.size() == 0) begin
        report($sformatf("record kind %0d offset %0d with nothing pending", kind, offset));
      end else begin
        w = expected_records.pop_front();
        if (kind === REC_UNIT) units_checked++;
        else params_checked++;
        if (kind !== w.kind)
          report($sformatf("record_kind got %0d want %0d", kind, w.kind));
        if (offset !== w.offset)
          report($sformatf("unit_offset got %0d want %0d", offset, w.offset));
        if (length !== w.length)
          report($sformatf("unit_length got %0d want %0d", length, w.length));
        if (ftime !== w.ftime)
          report($sformatf("frame_time got %0d want %0d", ftime, w.ftime));
        if (idr !== w.idr)
          report($sformatf("is_idr got %0d want %0d", idr, w.idr));
        if (last !== w.last)
          report($sformatf("last_result got %0d want %0d", last, w.last));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                last_byte;
  logic                out_valid;
  logic                out_stall;
  logic                record_kind;
  logic [31:0]         unit_offset;
  logic [31:0]         unit_length;
  logic [TIME_W-1:0]   frame_time;
  logic                is_idr;
  logic                last_result;

  au_scoreboard sb = new();
  logic [7:0]   stream_q[$];
  bit           calm = 1'b0;
  int           stall_left = 0;
  int           bytes_sent = 0;
  int           streams_sent = 0;
  int           periods_used = 1;

  annexb_access_unit_splitter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .record_kind (record_kind),
    .unit_offset (unit_offset),
    .unit_length (unit_length),
    .frame_time  (frame_time),
    .is_idr      (is_idr),
    .last_result (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d records still pending", sb.expected_records.size());
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall bursts, none in the calm phase.
  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_record(record_kind, unit_offset, unit_length, frame_time, is_idr,
                      last_result);
  end

  task send_byte(logic [7:0] b, logic l);
    data_byte <= b;
    last_byte <= l;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, l);
    bytes_sent++;
  endtask

  // Send the built stream; outside the calm phase add random gaps and drop valid after its last byte.
  task send_stream();
    int gap;
    for (int i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
      if (i == stream_q.size() - 1) begin
        if (!calm) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    streams_sent++;
  endtask

  // Drop valid, then hold until every pending record is out and the pipeline has emptied.
  task settle();
    in_valid <= 1'b0;
    while (sb.expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_period(logic [PERIOD_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.period = v;
    periods_used++;
    @(posedge clk);
  endtask

  function automatic void put_code(bit long_code);
    if (long_code) stream_q.insert(stream_q.size(), 8'h00);
    stream_q.insert(stream_q.size(), 8'h00);
    stream_q.insert(stream_q.size(), 8'h00);
    stream_q.insert(stream_q.size(), 8'h01);
  endfunction

  function automatic logic [4:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r <= 5) return 5'd1;
    if (r <= 9) return NAL_IDR;
    if (r <= 11) return NAL_SPS;
    if (r <= 13) return NAL_PPS;
    if (r == 14) return NAL_NONE;
    if (r == 15) return 5'd6;
    if (r == 16) return 5'd9;
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 1) return 8'h00;
    if (r == 2) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_stream();
    int nals, plen, ending;
    stream_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      // noise: zero-heavy bytes, with the occasional accidental start code
      repeat ($urandom_range(3, 40)) stream_q.insert(stream_q.size(), payload_byte());
      return;
    end
    repeat ($urandom_range(0, 3))
      stream_q.insert(stream_q.size(), 8'($urandom_range(0, 255)));
    nals = $urandom_range(1, 10);
    for (int i = 0; i < nals; i++) begin
      put_code(1'($urandom_range(0, 1)));
      stream_q.insert(stream_q.size(), {3'($urandom_range(0, 7)), pick_kind()});
      case ($urandom_range(0, 9))
        0, 1: plen = $urandom_range(0, 2);
        9:    plen = $urandom_range(9, 40);
        default: plen = $urandom_range(1, 8);
      endcase
      for (int j = 0; j < plen; j++)
        stream_q.insert(stream_q.size(),
                        j == 0 ? 8'($urandom_range(0, 255)) : payload_byte());
    end
    ending = $urandom_range(0, 7);
    if (ending == 0) begin
      put_code(1'b1);
    end else if (ending == 1) begin
      put_code(1'b0);
    end else if (ending == 2) begin
      put_code(1'b0);
      stream_q.insert(stream_q.size(), {3'($urandom_range(0, 7)), pick_kind()});
    end
  endfunction

  initial begin
    int phase_bytes;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // SPS, PPS, IDR closed by a slice with its top bit set, trailing slice at end
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF, 8'h00, 8'h00, 8'h01,
                 8'h68, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h80, 8'h00, 8'h00,
                 8'h01, 8'h21, 8'h9A};
    send_stream();
    // long code whose header byte never comes
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_stream();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: write_period(PERIOD_W'(1));
        1: write_period(PERIOD_W'(1000));
        4: write_period(FRAME_PERIOD_RESET);
        5: write_period(PERIOD_W'(1000));
        default: write_period(PERIOD_W'($urandom_range(2, 999)));
      endcase
      if (p == PHASES - 1) calm = 1'b1;
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < RANDOM_BYTES / PHASES) begin
        build_stream();
        send_stream();
      end
    end

    settle();
    $display("Sent %0d bytes in %0d streams under %0d frame period settings",
             bytes_sent, streams_sent, periods_used);
    $display("Checked %0d access unit records and %0d parameter set records, %0d mismatches",
             sb.units_checked, sb.params_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
